// File: rtl/core/plen_pkg.sv
// Package with the shared widths, limits and sequencer states of the polyline length block.
`timescale 1ns / 1ps
`default_nettype none

package plen_pkg;

   localparam int unsigned CoordWidth  = 24;
   localparam int unsigned DiffWidth   = CoordWidth + 1;
   localparam int unsigned SquareWidth = 48;
   localparam int unsigned RadWidth    = 50;
   localparam int unsigned RootWidth   = 25;
   localparam int unsigned RemWidth    = RootWidth + 1;
   localparam int unsigned SegWidth    = 26;
   localparam int unsigned SumWidth    = 48;
   localparam int unsigned StepWidth   = 5;

   localparam logic [StepWidth-1:0] LastStep = StepWidth'(RootWidth - 1);
   localparam logic [SumWidth-1:0]  SumMax   = {SumWidth{1'b1}};

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SQX    = 6'b000010,
      ST_SQY    = 6'b000100,
      ST_SUM    = 6'b001000,
      ST_ROOT   = 6'b010000,
      ST_ACC    = 6'b100000
   } state_type;

endpackage

`default_nettype wire

// File: rtl/core/polyline_length_accumulator.sv
// Top level of the polyline length accumulator: squares, bit-serial root and saturating sums.
//
// The block measures polylines given one point per item on the req_ channel, as signed
// Q16.8 coordinates with a chain_start flag (first point of a chain) and a set_start flag
// (clears the set total and also starts a chain). For every item it returns one item on
// the rsp_ channel: the segment length to the previous point (zero at a chain start), the
// chain length so far and the set total so far, all in Q.8. The sums saturate at 2^48-1.
// An item is accepted at a clock edge where valid is high and stall is low.
// A point that continues a chain passes SQX and SQY, where one shared 25x25 multiplier
// squares dx and then dy, SUM, which adds the squares, ROOT, where a restoring square root
// unit retires one root bit per cycle, and ACC, which updates the sums. A chain or set
// start skips all of this and goes from idle straight to ACC. The block accepts a new
// item once it is back in idle, so it takes no new point while it works on the last one.
// The result register parts the two sides: a new item is accepted while an earlier result
// still waits. If the receiver stalls, the result holds and the block waits in its final
// step before it overwrites the result. Synchronous reset clears the stored point to
// (0,0), both sums to zero and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module polyline_length_accumulator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [plen_pkg::CoordWidth-1:0] req_point_x,
   input  wire logic signed [plen_pkg::CoordWidth-1:0] req_point_y,
   input  wire logic                                req_chain_start,
   input  wire logic                                req_set_start,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [plen_pkg::SegWidth-1:0]            rsp_segment_length,
   output logic [plen_pkg::SumWidth-1:0]            rsp_chain_length,
   output logic [plen_pkg::SumWidth-1:0]            rsp_total_length
);

   plen_pkg::state_type state_ff, state_in;

   // Stored point and accumulators; these are the architectural state.
   logic signed [plen_pkg::CoordWidth-1:0] prev_x_ff;
   logic signed [plen_pkg::CoordWidth-1:0] prev_y_ff;
   logic [plen_pkg::SumWidth-1:0]          chain_sum_ff, chain_sum_in;
   logic [plen_pkg::SumWidth-1:0]          total_sum_ff, total_sum_in;
   logic                                   rsp_valid_ff;

   // Per-item working registers.
   logic                                   start_ff;
   logic                                   set_ff;
   logic signed [plen_pkg::DiffWidth-1:0]  dx_ff, dy_ff;
   logic [plen_pkg::SquareWidth-1:0]       prod_ff;
   logic [plen_pkg::RadWidth-1:0]          rad_ff;
   logic [plen_pkg::RemWidth-1:0]          rem_ff;
   logic [plen_pkg::RootWidth-1:0]         root_ff;
   logic [plen_pkg::StepWidth-1:0]         step_ff;
   logic [plen_pkg::SegWidth-1:0]          seg_out_ff;

   logic                                   req_take;
   logic                                   rsp_take;
   logic                                   out_free;
   logic signed [plen_pkg::DiffWidth-1:0]  dx_in, dy_in;
   logic signed [plen_pkg::DiffWidth-1:0]  mul_op;
   logic signed [2*plen_pkg::DiffWidth-1:0] prod_full;
   logic [plen_pkg::RemWidth+1:0]          root_cand;
   logic [plen_pkg::RemWidth+1:0]          root_sub;
   logic [plen_pkg::RemWidth+2:0]          root_diff;
   logic                                   root_ge;
   logic [plen_pkg::SegWidth-1:0]          seg_val;
   logic [plen_pkg::SumWidth:0]            chain_add;
   logic [plen_pkg::SumWidth:0]            total_add;

   assign req_stall = (state_ff != plen_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   // The result register may be overwritten once it is empty or being taken now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Coordinate differences, one bit wider so they never wrap.
   assign dx_in = $signed({req_point_x[plen_pkg::CoordWidth-1], req_point_x})
                - $signed({prev_x_ff[plen_pkg::CoordWidth-1], prev_x_ff});
   assign dy_in = $signed({req_point_y[plen_pkg::CoordWidth-1], req_point_y})
                - $signed({prev_y_ff[plen_pkg::CoordWidth-1], prev_y_ff});

   // The single multiplier squares dx first and dy in the next cycle. A signed square is
   // never negative and stays below 2^48.
   assign mul_op    = (state_ff == plen_pkg::ST_SQX) ? dx_ff : dy_ff;
   assign prod_full = mul_op * mul_op;

   // Restoring square root step: bring down the next two radicand bits and try to
   // subtract 4*root+1. A non-negative difference means the next root bit is one.
   assign root_cand = {rem_ff, rad_ff[plen_pkg::RadWidth-1 -: 2]};
   assign root_sub  = {1'b0, root_ff, 2'b01};
   assign root_diff = {1'b0, root_cand} - {1'b0, root_sub};
   assign root_ge   = !root_diff[plen_pkg::RemWidth+2];

   // Segment length for this item and the saturating sums.
   assign seg_val   = start_ff ? '0 : {1'b0, root_ff};
   assign chain_add = {1'b0, chain_sum_ff} + {{(plen_pkg::SumWidth-plen_pkg::SegWidth+1){1'b0}},
                                              seg_val};
   assign total_add = {1'b0, total_sum_ff} + {{(plen_pkg::SumWidth-plen_pkg::SegWidth+1){1'b0}},
                                              seg_val};

   always_comb begin
      if (start_ff) begin
         chain_sum_in = '0;
      end else if (chain_add[plen_pkg::SumWidth]) begin
         chain_sum_in = plen_pkg::SumMax;
      end else begin
         chain_sum_in = chain_add[plen_pkg::SumWidth-1:0];
      end

      if (set_ff) begin
         total_sum_in = '0;
      end else if (start_ff) begin
         total_sum_in = total_sum_ff;
      end else if (total_add[plen_pkg::SumWidth]) begin
         total_sum_in = plen_pkg::SumMax;
      end else begin
         total_sum_in = total_add[plen_pkg::SumWidth-1:0];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plen_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_chain_start || req_set_start) begin
                  state_in = plen_pkg::ST_ACC;
               end else begin
                  state_in = plen_pkg::ST_SQX;
               end
            end
         end
         plen_pkg::ST_SQX: begin
            state_in = plen_pkg::ST_SQY;
         end
         plen_pkg::ST_SQY: begin
            state_in = plen_pkg::ST_SUM;
         end
         plen_pkg::ST_SUM: begin
            state_in = plen_pkg::ST_ROOT;
         end
         plen_pkg::ST_ROOT: begin
            if (step_ff == plen_pkg::LastStep) begin
               state_in = plen_pkg::ST_ACC;
            end
         end
         plen_pkg::ST_ACC: begin
            if (out_free) begin
               state_in = plen_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plen_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plen_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         chain_sum_ff <= '0;
         total_sum_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (req_take) begin
            prev_x_ff <= req_point_x;
            prev_y_ff <= req_point_y;
         end
         if (state_ff == plen_pkg::ST_ACC && out_free) begin
            rsp_valid_ff <= 1'b1;
            chain_sum_ff <= chain_sum_in;
            total_sum_ff <= total_sum_in;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         start_ff <= req_chain_start || req_set_start;
         set_ff   <= req_set_start;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
      end

      if (state_ff == plen_pkg::ST_SQX || state_ff == plen_pkg::ST_SQY) begin
         prod_ff <= prod_full[plen_pkg::SquareWidth-1:0];
      end

      if (state_ff == plen_pkg::ST_SQY) begin
         rad_ff <= {{(plen_pkg::RadWidth-plen_pkg::SquareWidth){1'b0}}, prod_ff};
      end else if (state_ff == plen_pkg::ST_SUM) begin
         rad_ff  <= rad_ff + {{(plen_pkg::RadWidth-plen_pkg::SquareWidth){1'b0}}, prod_ff};
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end else if (state_ff == plen_pkg::ST_ROOT) begin
         rad_ff  <= {rad_ff[plen_pkg::RadWidth-3:0], 2'b00};
         rem_ff  <= root_ge ? root_diff[plen_pkg::RemWidth-1:0]
                            : root_cand[plen_pkg::RemWidth-1:0];
         root_ff <= {root_ff[plen_pkg::RootWidth-2:0], root_ge};
         step_ff <= step_ff + plen_pkg::StepWidth'(1);
      end

      if (state_ff == plen_pkg::ST_ACC && out_free) begin
         seg_out_ff <= seg_val;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segment_length = seg_out_ff;
   assign rsp_chain_length   = chain_sum_ff;
   assign rsp_total_length   = total_sum_ff;

endmodule

`default_nettype wire

// File: test/tb_polyline_length_accumulator.sv
// Self-checking testbench for the polyline length accumulator with its own length predictor.
`timescale 1ns / 1ps

module tb_polyline_length_accumulator;

   typedef logic signed [plen_pkg::CoordWidth-1:0] coord_type;

   // One expected result item: segment length, chain length and set total, all in Q.8.
   typedef struct packed {
      logic [plen_pkg::SegWidth-1:0] segment;
      logic [plen_pkg::SumWidth-1:0] chain;
      logic [plen_pkg::SumWidth-1:0] total;
   } length_result_type;

   localparam coord_type CoordMin = {1'b1, {(plen_pkg::CoordWidth-1){1'b0}}};
   localparam coord_type CoordMax = {1'b0, {(plen_pkg::CoordWidth-1){1'b1}}};

   // A margin after the drain that catches any late or stray result.
   localparam int unsigned SettleCycles = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic      req_valid       = 1'b0;
   logic      req_stall;
   coord_type req_point_x     = '0;
   coord_type req_point_y     = '0;
   logic      req_chain_start = 1'b0;
   logic      req_set_start   = 1'b0;

   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [plen_pkg::SegWidth-1:0] rsp_segment_length;
   logic [plen_pkg::SumWidth-1:0] rsp_chain_length;
   logic [plen_pkg::SumWidth-1:0] rsp_total_length;

   // Idle rates in percent of cycles, changed between the phases of the run.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned mismatches     = 0;

   // Lengths that the block must still deliver, oldest first.
   length_result_type pending_lengths[$];

   // The predictor's copy of the block state: the last point and the two running sums.
   coord_type                     last_x    = '0;
   coord_type                     last_y    = '0;
   logic [plen_pkg::SumWidth-1:0] chain_run = '0;
   logic [plen_pkg::SumWidth-1:0] set_run   = '0;

   polyline_length_accumulator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_chain_start    (req_chain_start),
      .req_set_start      (req_set_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_segment_length (rsp_segment_length),
      .rsp_chain_length   (rsp_chain_length),
      .rsp_total_length   (rsp_total_length)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The sums stick at their largest value instead of wrapping.
   function automatic logic [plen_pkg::SumWidth-1:0] add_saturated(
         input logic [plen_pkg::SumWidth-1:0] acc,
         input logic [plen_pkg::SegWidth-1:0] seg);
      logic [plen_pkg::SumWidth:0] wide;
      wide = {1'b0, acc} + seg;
      return (wide > plen_pkg::SumMax) ? plen_pkg::SumMax : wide[plen_pkg::SumWidth-1:0];
   endfunction

   // Works out the result item for one accepted point and advances the predicted state.
   // The root is found by trial from the top bit down: a bit stays set while the square
   // of the partial root does not exceed the sum of squares, which yields the floor.
   function automatic length_result_type measure_point(input coord_type x, input coord_type y,
                                                       input bit chain_flag,
                                                       input bit set_flag);
      longint            dx;
      longint            dy;
      longint unsigned   squares;
      longint unsigned   root;
      longint unsigned   trial;
      length_result_type r;
      r.segment = '0;
      if (set_flag)
         set_run = '0;
      if (set_flag || chain_flag) begin
         // A start point forms no segment; only the chain sum is cleared here.
         chain_run = '0;
      end else begin
         dx = longint'(x) - longint'(last_x);
         dy = longint'(y) - longint'(last_y);
         squares = dx * dx + dy * dy;
         root = 0;
         for (int b = plen_pkg::RootWidth; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= squares)
               root = trial;
         end
         r.segment = root[plen_pkg::SegWidth-1:0];
         chain_run = add_saturated(chain_run, r.segment);
         set_run   = add_saturated(set_run, r.segment);
      end
      last_x  = x;
      last_y  = y;
      r.chain = chain_run;
      r.total = set_run;
      return r;
   endfunction

   // Presents one point, holds it until the block takes it, then records the expected lengths.
   // Valid stays high on return, so back-to-back items need no extra edge.
   task automatic send_point(input coord_type x, input coord_type y,
                             input bit chain_flag, input bit set_flag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_point_x     <= x;
      req_point_y     <= y;
      req_chain_start <= chain_flag;
      req_set_start   <= set_flag;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_lengths.push_back(measure_point(x, y, chain_flag, set_flag));
   endtask

   // Holds the sender back until the block has delivered every outstanding item.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_lengths.size() != 0)
         @(posedge clock);
   endtask

   // The receiver stalls at random; the rate is set per phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic compare_field(input string field, input logic [plen_pkg::SumWidth-1:0] want,
                                input logic [plen_pkg::SumWidth-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Every result item that the block hands over is matched against the oldest expectation.
   always @(posedge clock) begin
      length_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lengths.size() == 0) begin
            $display("%0t ns: result item with nothing expected, segment %0d", $time,
                     rsp_segment_length);
            mismatches++;
         end else begin
            want = pending_lengths.pop_front();
            compare_field("segment_length", want.segment, rsp_segment_length);
            compare_field("chain_length", want.chain, rsp_chain_length);
            compare_field("total_length", want.total, rsp_total_length);
         end
      end
   end

   // Right after reset the stored point is the origin, so a first point without any
   // start flag is measured from (0,0): a 3-4-5 triangle gives exactly 5.0.
   task automatic test_reset_origin();
      send_point(coord_type'(24'h000300), coord_type'(24'h000400), 1'b0, 1'b0);
      send_point(coord_type'(0), coord_type'(0), 1'b0, 1'b0);
   endtask

   // Corner to corner gives the longest segment the block can see; other moves run along one
   // axis, repeat a point, cross to near the origin, and step by a single fraction bit.
   task automatic test_coordinate_extremes();
      send_point(CoordMin, CoordMin, 1'b0, 1'b1);
      send_point(CoordMax, CoordMax, 1'b0, 1'b0);
      send_point(CoordMin, CoordMax, 1'b0, 1'b0);
      send_point(CoordMin, CoordMin, 1'b0, 1'b0);
      send_point(CoordMin, CoordMin, 1'b0, 1'b0);
      send_point(CoordMax, CoordMin, 1'b0, 1'b0);
      send_point(coord_type'(-1), coord_type'(-1), 1'b0, 1'b0);
      send_point(coord_type'(0), coord_type'(0), 1'b0, 1'b0);
      send_point(coord_type'(1), coord_type'(0), 1'b0, 1'b0);
      send_point(coord_type'(1), coord_type'(1), 1'b0, 1'b0);
   endtask

   // A chain start keeps the set total, a set start clears it, and both flags together
   // behave as a set start. Each start is followed by a continuing point.
   task automatic test_chain_and_set_flags();
      send_point(coord_type'(24'h123456), coord_type'(-5), 1'b1, 1'b0);
      send_point(coord_type'(24'h123456), coord_type'(24'h000A00), 1'b0, 1'b0);
      send_point(coord_type'(24'h7F0000), coord_type'(24'h810000), 1'b1, 1'b0);
      send_point(coord_type'(24'h7F1234), coord_type'(24'h80FFFF), 1'b0, 1'b0);
      send_point(coord_type'(24'h555555), coord_type'(24'hAAAAAA), 1'b0, 1'b1);
      send_point(coord_type'(24'hAAAAAA), coord_type'(24'h555555), 1'b0, 1'b0);
      send_point(coord_type'(-200), coord_type'(300), 1'b1, 1'b1);
      send_point(coord_type'(100), coord_type'(-100), 1'b0, 1'b0);
      send_point(coord_type'(100), coord_type'(-100), 1'b1, 1'b0);
      send_point(coord_type'(50), coord_type'(-50), 1'b0, 1'b0);
   endtask

   // Next coordinate of a polyline: often a short or medium hop from the last one, some
   // uniform over the full range, some pinned to the ends of the range or to 0 or -1.
   function automatic coord_type pick_coord(input coord_type from);
      case ($urandom_range(5))
         0, 1: return from + coord_type'($urandom_range(511)) - coord_type'(256);
         2:    return from + coord_type'($urandom_range(131071)) - coord_type'(65536);
         3:    return coord_type'($urandom);
         default: begin
            case ($urandom_range(3))
               0:       return CoordMin;
               1:       return CoordMax;
               2:       return coord_type'(0);
               default: return coord_type'(-1);
            endcase
         end
      endcase
   endfunction

   // Sets of polylines: a set start, then chains that each open with a chain start and
   // carry on with one to twelve continuing points. About one item in ten carries random flags
   // so that odd orders of starts are also seen.
   task automatic test_random_polylines(input int unsigned item_count);
      int unsigned sent;
      int unsigned chains;
      int unsigned points;
      coord_type   x;
      coord_type   y;
      sent = 0;
      x = coord_type'($urandom);
      y = coord_type'($urandom);
      while (sent < item_count) begin
         chains = $urandom_range(4, 1);
         for (int c = 0; c < chains; c++) begin
            x = pick_coord(x);
            y = pick_coord(y);
            if (c == 0)
               send_point(x, y, 1'($urandom_range(1)), 1'b1);
            else
               send_point(x, y, 1'b1, 1'b0);
            sent++;
            points = $urandom_range(12, 1);
            for (int p = 0; p < points; p++) begin
               x = pick_coord(x);
               y = pick_coord(y);
               if ($urandom_range(9) == 0)
                  send_point(x, y, 1'($urandom_range(1)), 1'($urandom_range(1)));
               else
                  send_point(x, y, 1'b0, 1'b0);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender mostly busy, receiver mostly stalled.
      send_idle_pct  = 9;
      recv_stall_pct = 80;
      test_reset_origin();
      test_coordinate_extremes();
      drain_results();
      test_chain_and_set_flags();
      test_random_polylines(170);
      drain_results();

      // Sender mostly idle, receiver mostly ready.
      send_idle_pct  = 80;
      recv_stall_pct = 9;
      test_random_polylines(170);
      drain_results();

      // Neither side idles.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_polylines(180);

      drain_results();
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0)
         $display("tb_polyline_length_accumulator: PASS");
      else
         $display("tb_polyline_length_accumulator: FAIL");
      $finish;
   end

   // Far beyond the slowest correct run, even with every result stalled for long stretches.
   initial begin
      #10_000_000;
      $display("tb_polyline_length_accumulator: FAIL");
      $finish;
   end

endmodule
